// ===== hw/rtl/fsa_pkg.sv =====
package fsa_pkg;

   localparam int CELL_W = 16;
   localparam int DBL_W  = 2 * CELL_W;
   localparam int OUT_W  = 32;

   localparam logic [CELL_W-1:0] CHAR_ZERO = CELL_W'(8'h30);
   localparam logic [CELL_W-1:0] CHAR_NINE = CELL_W'(8'h39);
   localparam logic [CELL_W-1:0] CHAR_LA   = CELL_W'(8'h61);
   localparam logic [CELL_W-1:0] CHAR_LZ   = CELL_W'(8'h7a);
   localparam logic [CELL_W-1:0] DIGIT_OFS = CELL_W'(10);

   typedef enum logic [4:0] {
      OP_PLUS    = 5'd0,
      OP_MINUS   = 5'd1,
      OP_MUL     = 5'd2,
      OP_INC     = 5'd3,
      OP_DEC     = 5'd4,
      OP_SMOD    = 5'd5,
      OP_INC2    = 5'd6,
      OP_DEC2    = 5'd7,
      OP_HALF    = 5'd8,
      OP_ABS     = 5'd9,
      OP_TWICE   = 5'd10,
      OP_DPLUS   = 5'd11,
      OP_DNEGATE = 5'd12,
      OP_MAX     = 5'd13,
      OP_MIN     = 5'd14,
      OP_NEGATE  = 5'd15,
      OP_UMUL    = 5'd16,
      OP_TRUE    = 5'd17,
      OP_FALSE   = 5'd18,
      OP_DUMOD   = 5'd19,
      OP_UMOD    = 5'd20,
      OP_DIGIT   = 5'd21
   } opcode_type;

   // control and plain results that ride alongside the divider
   typedef struct packed {
      logic [2:0]       pop_cells;
      logic [1:0]       push_count;
      logic             push_is_double;
      logic             is_div;
      logic             signed_div;
      logic             neg_quo;
      logic             neg_rem;
      logic             div_zero;
      logic [OUT_W-1:0] first_push;
      logic [OUT_W-1:0] second_push;
   } ctrl_type;

   // restoring divider state
   typedef struct packed {
      logic [DBL_W-1:0] rem;
      logic [DBL_W-1:0] quo;
      logic [DBL_W-1:0] dvs;
   } div_type;

endpackage

// ===== hw/rtl/fsa_if.sv =====
interface fsa_req_if;
   import fsa_pkg::*;
   logic              valid;
   logic              ready;
   logic [4:0]        opcode;
   logic [CELL_W-1:0] top_cell;
   logic [CELL_W-1:0] second_cell;
   logic [DBL_W-1:0]  top_double;
   logic [DBL_W-1:0]  second_double;
   modport source(output valid, opcode, top_cell, second_cell, top_double, second_double,
                  input ready);
   modport sink(input valid, opcode, top_cell, second_cell, top_double, second_double,
                output ready);
endinterface

interface fsa_rsp_if;
   import fsa_pkg::*;
   logic             valid;
   logic             ready;
   logic [2:0]       pop_cells;
   logic [1:0]       push_count;
   logic             push_is_double;
   logic [OUT_W-1:0] first_push;
   logic [OUT_W-1:0] second_push;
   modport source(output valid, pop_cells, push_count, push_is_double, first_push,
                  second_push, input ready);
   modport sink(input valid, pop_cells, push_count, push_is_double, first_push,
                second_push, output ready);
endinterface

// ===== hw/rtl/fsa_decode.sv =====
module fsa_decode (
   input  logic [4:0]                opcode,
   input  logic [fsa_pkg::CELL_W-1:0] top_cell,
   input  logic [fsa_pkg::CELL_W-1:0] second_cell,
   input  logic [fsa_pkg::DBL_W-1:0]  top_double,
   input  logic [fsa_pkg::DBL_W-1:0]  second_double,
   output fsa_pkg::ctrl_type         ctrl,
   output fsa_pkg::div_type          div
);
   import fsa_pkg::*;

   logic [CELL_W-1:0] t, s, t_abs, s_abs, half, digit_val;
   logic              t_neg, s_neg, s_lt_t, digit_ok;
   logic [DBL_W-1:0]  prod;

   assign t     = top_cell;
   assign s     = second_cell;
   assign t_neg = t[CELL_W-1];
   assign s_neg = s[CELL_W-1];
   assign t_abs = t_neg ? (CELL_W'(0) - t) : t;
   assign s_abs = s_neg ? (CELL_W'(0) - s) : s;
   assign half  = CELL_W'(($signed({t_neg, t}) + $signed({{CELL_W{1'b0}}, t_neg})) >>> 1);
   assign s_lt_t = $signed(s) < $signed(t);
   assign prod  = DBL_W'(t) * DBL_W'(s);

   // digit conversion with base check
   always_comb begin
      digit_val = '0;
      digit_ok  = 1'b0;
      if (s >= CHAR_ZERO && s <= CHAR_NINE) begin
         digit_val = s - CHAR_ZERO;
         digit_ok  = 1'b1;
      end else if (s >= CHAR_LA && s <= CHAR_LZ) begin
         digit_val = s - CHAR_LA + DIGIT_OFS;
         digit_ok  = 1'b1;
      end
      if (digit_val >= t) digit_ok = 1'b0;
   end

   // word decode
   always_comb begin
      ctrl = '0;
      div  = '0;
      unique case (opcode)
         OP_PLUS: begin
            ctrl.pop_cells = 3'd2; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'(CELL_W'(s + t));
         end
         OP_MINUS: begin
            ctrl.pop_cells = 3'd2; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'(CELL_W'(s - t));
         end
         OP_MUL: begin
            ctrl.pop_cells = 3'd2; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'(prod[CELL_W-1:0]);
         end
         OP_INC: begin
            ctrl.pop_cells = 3'd1; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'(CELL_W'(t + CELL_W'(1)));
         end
         OP_DEC: begin
            ctrl.pop_cells = 3'd1; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'(CELL_W'(t - CELL_W'(1)));
         end
         OP_SMOD: begin
            ctrl.pop_cells = 3'd2; ctrl.push_count = 2'd2;
            ctrl.is_div = 1'b1; ctrl.signed_div = 1'b1;
            ctrl.neg_quo = s_neg ^ t_neg; ctrl.neg_rem = s_neg;
            ctrl.div_zero = (t == '0);
            div.quo = DBL_W'(s_abs); div.dvs = DBL_W'(t_abs);
         end
         OP_INC2: begin
            ctrl.pop_cells = 3'd1; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'(CELL_W'(t + CELL_W'(2)));
         end
         OP_DEC2: begin
            ctrl.pop_cells = 3'd1; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'(CELL_W'(t - CELL_W'(2)));
         end
         OP_HALF: begin
            ctrl.pop_cells = 3'd1; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'(half);
         end
         OP_ABS: begin
            ctrl.pop_cells = 3'd1; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'(t_abs);
         end
         OP_TWICE: begin
            ctrl.pop_cells = 3'd1; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'({t[CELL_W-2:0], 1'b0});
         end
         OP_DPLUS: begin
            ctrl.pop_cells = 3'd4; ctrl.push_count = 2'd1; ctrl.push_is_double = 1'b1;
            ctrl.first_push = OUT_W'(DBL_W'(top_double + second_double));
         end
         OP_DNEGATE: begin
            ctrl.pop_cells = 3'd2; ctrl.push_count = 2'd1; ctrl.push_is_double = 1'b1;
            ctrl.first_push = OUT_W'(DBL_W'(DBL_W'(0) - top_double));
         end
         OP_MAX: begin
            ctrl.pop_cells = 3'd2; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'(s_lt_t ? t : s);
         end
         OP_MIN: begin
            ctrl.pop_cells = 3'd2; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'((!s_lt_t && s != t) ? t : s);
         end
         OP_NEGATE: begin
            ctrl.pop_cells = 3'd1; ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'(CELL_W'(CELL_W'(0) - t));
         end
         OP_UMUL: begin
            ctrl.pop_cells = 3'd2; ctrl.push_count = 2'd1; ctrl.push_is_double = 1'b1;
            ctrl.first_push = OUT_W'(prod);
         end
         OP_TRUE: begin
            ctrl.push_count = 2'd1;
            ctrl.first_push = OUT_W'({CELL_W{1'b1}});
         end
         OP_FALSE: begin
            ctrl.push_count = 2'd1;
         end
         OP_DUMOD: begin
            ctrl.pop_cells = 3'd4; ctrl.push_count = 2'd2; ctrl.push_is_double = 1'b1;
            ctrl.is_div = 1'b1; ctrl.div_zero = (top_double == '0);
            div.quo = second_double; div.dvs = top_double;
         end
         OP_UMOD: begin
            ctrl.pop_cells = 3'd2; ctrl.push_count = 2'd2;
            ctrl.is_div = 1'b1; ctrl.div_zero = (t == '0);
            div.quo = DBL_W'(s); div.dvs = DBL_W'(t);
         end
         OP_DIGIT: begin
            ctrl.pop_cells = 3'd2;
            if (digit_ok) begin
               ctrl.push_count = 2'd2;
               ctrl.first_push = OUT_W'(digit_val);
               ctrl.second_push = OUT_W'({CELL_W{1'b1}});
            end else begin
               ctrl.push_count = 2'd1;
            end
         end
         default: ctrl = '0;
      endcase
   end

endmodule

// ===== hw/rtl/fsa_div_stage.sv =====
module fsa_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              valid_in,
   input  fsa_pkg::ctrl_type ctrl_in,
   input  fsa_pkg::div_type  div_in,
   output logic              valid_out,
   output fsa_pkg::ctrl_type ctrl_out,
   output fsa_pkg::div_type  div_out
);
   import fsa_pkg::*;

   logic              valid_ff, valid_ff_in;
   ctrl_type          ctrl_ff, ctrl_ff_in;
   div_type           div_ff, div_ff_in;
   logic [DBL_W:0]    shifted, diff;
   logic              ge;

   // one restoring step: shift in the next dividend bit, try subtract
   assign shifted = {div_in.rem, div_in.quo[DBL_W-1]};
   assign diff    = shifted - {1'b0, div_in.dvs};
   assign ge      = !diff[DBL_W];

   always_comb begin
      valid_ff_in   = valid_in;
      ctrl_ff_in    = ctrl_in;
      div_ff_in.dvs = div_in.dvs;
      div_ff_in.rem = ge ? diff[DBL_W-1:0] : shifted[DBL_W-1:0];
      div_ff_in.quo = {div_in.quo[DBL_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_ff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctrl_ff <= ctrl_ff_in;
         div_ff  <= div_ff_in;
      end
   end

   assign valid_out = valid_ff;
   assign ctrl_out  = ctrl_ff;
   assign div_out   = div_ff;

endmodule

// ===== hw/rtl/fsa_finish.sv =====
module fsa_finish (
   input  fsa_pkg::ctrl_type            ctrl,
   input  fsa_pkg::div_type             div,
   output logic [fsa_pkg::OUT_W-1:0]    first_push,
   output logic [fsa_pkg::OUT_W-1:0]    second_push
);
   import fsa_pkg::*;

   logic [CELL_W-1:0] q_cell, r_cell;

   // sign fix for the signed cell division
   assign q_cell = ctrl.neg_quo ? (CELL_W'(0) - div.quo[CELL_W-1:0]) : div.quo[CELL_W-1:0];
   assign r_cell = ctrl.neg_rem ? (CELL_W'(0) - div.rem[CELL_W-1:0]) : div.rem[CELL_W-1:0];

   always_comb begin
      priority if (!ctrl.is_div) begin
         first_push  = ctrl.first_push;
         second_push = ctrl.second_push;
      end else if (ctrl.div_zero) begin
         first_push  = '0;
         second_push = '0;
      end else if (ctrl.signed_div) begin
         first_push  = OUT_W'(r_cell);
         second_push = OUT_W'(q_cell);
      end else begin
         first_push  = OUT_W'(div.rem);
         second_push = OUT_W'(div.quo);
      end
   end

endmodule

// ===== hw/rtl/forth_stack_alu.sv =====
// Forth arithmetic word unit. Each request beat carries one word and its stack
// operands; each response beat gives the cells to pop and up to two values to
// push. One beat is accepted every cycle unless the response side stalls; a
// response passes the decode stage, 32 restoring divider stages at one quotient
// bit each and the output register, the same path for every word so order is
// kept. A stall on the response side holds the whole pipeline.
module forth_stack_alu (
   input  logic       clock,
   input  logic       reset,
   fsa_req_if.sink    req_chan,
   fsa_rsp_if.source  rsp_chan
);
   import fsa_pkg::*;

   localparam int STEPS = DBL_W;

   logic              enable;
   ctrl_type          dec_ctrl;
   div_type           dec_div;
   logic              v0_ff;
   ctrl_type          ctrl0_ff;
   div_type           div0_ff;
   logic              v_st    [STEPS+1];
   ctrl_type          ctrl_st [STEPS+1];
   div_type           div_st  [STEPS+1];
   logic [OUT_W-1:0]  fin_first, fin_second;
   logic              rsp_valid_ff, rsp_valid_ff_in;
   logic [2:0]        pop_ff;
   logic [1:0]        cnt_ff;
   logic              dbl_ff;
   logic [OUT_W-1:0]  first_ff, second_ff;

   assign enable         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = enable;

   fsa_decode u_decode (
      .opcode        (req_chan.opcode),
      .top_cell      (req_chan.top_cell),
      .second_cell   (req_chan.second_cell),
      .top_double    (req_chan.top_double),
      .second_double (req_chan.second_double),
      .ctrl          (dec_ctrl),
      .div           (dec_div)
   );

   // decode stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctrl0_ff <= dec_ctrl;
         div0_ff  <= dec_div;
      end
   end

   assign v_st[0]    = v0_ff;
   assign ctrl_st[0] = ctrl0_ff;
   assign div_st[0]  = div0_ff;

   // divider chain
   for (genvar i = 0; i < STEPS; i++) begin : g_div
      fsa_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .valid_in  (v_st[i]),
         .ctrl_in   (ctrl_st[i]),
         .div_in    (div_st[i]),
         .valid_out (v_st[i+1]),
         .ctrl_out  (ctrl_st[i+1]),
         .div_out   (div_st[i+1])
      );
   end

   fsa_finish u_finish (
      .ctrl        (ctrl_st[STEPS]),
      .div         (div_st[STEPS]),
      .first_push  (fin_first),
      .second_push (fin_second)
   );

   // output register
   assign rsp_valid_ff_in = v_st[STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= rsp_valid_ff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pop_ff    <= ctrl_st[STEPS].pop_cells;
         cnt_ff    <= ctrl_st[STEPS].push_count;
         dbl_ff    <= ctrl_st[STEPS].push_is_double;
         first_ff  <= fin_first;
         second_ff <= fin_second;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.pop_cells      = pop_ff;
   assign rsp_chan.push_count     = cnt_ff;
   assign rsp_chan.push_is_double = dbl_ff;
   assign rsp_chan.first_push     = first_ff;
   assign rsp_chan.second_push    = second_ff;

   // single-cell results never carry upper bits
   a_cell_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !dbl_ff) |-> (first_ff[OUT_W-1:CELL_W] == '0 &&
                                     second_ff[OUT_W-1:CELL_W] == '0))
      else $error("single-cell result has upper bits set");

   // a value that is not pushed reads as zero
   a_unused_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && cnt_ff != 2'd2) |-> (second_ff == '0))
      else $error("second push nonzero while not pushed");

   a_unused_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && cnt_ff == 2'd0) |-> (first_ff == '0 && pop_ff == 3'd0))
      else $error("empty result carries data");

   // pipeline advances only when the output can move
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(v_st[STEPS]))
      else $error("pipeline moved during stall");

endmodule

// ===== tb/sv/forth_stack_alu_checker.sv =====
module forth_stack_alu_checker
   import fsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fsa_req_if.sink    req_mon,
   fsa_rsp_if.sink    rsp_mon,
   output int         fail_count,
   output int         pending_count,
   output int         rsp_seen
);

   typedef struct packed {
      logic [2:0]       pop_cells;
      logic [1:0]       push_count;
      logic             push_is_double;
      logic [OUT_W-1:0] first_push;
      logic [OUT_W-1:0] second_push;
   } word_result_type;

   word_result_type expected_results[$];

   // compute the effect of one forth word on the stack
   function automatic word_result_type eval_word(logic [4:0] op, logic [CELL_W-1:0] t,
                                                 logic [CELL_W-1:0] s,
                                                 logic [DBL_W-1:0] td,
                                                 logic [DBL_W-1:0] sd);
      word_result_type r;
      logic signed [CELL_W-1:0] st;
      logic signed [CELL_W-1:0] ss;
      logic [DBL_W-1:0] p1;
      logic [DBL_W-1:0] p2;
      logic [CELL_W-1:0] dval;
      logic dok;
      st = t;
      ss = s;
      p1 = '0;
      p2 = '0;
      r = '0;
      dval = '0;
      dok = 1'b1;
      case (op)
         OP_PLUS: begin r.pop_cells = 2; r.push_count = 1; p1 = CELL_W'(s + t); end
         OP_MINUS: begin r.pop_cells = 2; r.push_count = 1; p1 = CELL_W'(s - t); end
         OP_MUL: begin r.pop_cells = 2; r.push_count = 1; p1 = CELL_W'(s * t); end
         OP_INC: begin r.pop_cells = 1; r.push_count = 1; p1 = CELL_W'(t + 1'b1); end
         OP_DEC: begin r.pop_cells = 1; r.push_count = 1; p1 = CELL_W'(t - 1'b1); end
         OP_SMOD: begin
            r.pop_cells = 2; r.push_count = 2;
            if (t != 0) begin
               // truncating division, min / -1 wraps
               p1 = $unsigned(CELL_W'(ss % st));
               p2 = $unsigned(CELL_W'(ss / st));
            end
         end
         OP_INC2: begin r.pop_cells = 1; r.push_count = 1; p1 = CELL_W'(t + 2'd2); end
         OP_DEC2: begin r.pop_cells = 1; r.push_count = 1; p1 = CELL_W'(t - 2'd2); end
         OP_HALF: begin
            r.pop_cells = 1; r.push_count = 1;
            p1 = $unsigned(CELL_W'(st / $signed(3'sd2)));
         end
         OP_ABS: begin
            r.pop_cells = 1; r.push_count = 1;
            p1 = st[CELL_W-1] ? CELL_W'(-st) : t;
         end
         OP_TWICE: begin r.pop_cells = 1; r.push_count = 1; p1 = CELL_W'(t << 1); end
         OP_DPLUS: begin
            r.pop_cells = 4; r.push_count = 1; r.push_is_double = 1; p1 = td + sd;
         end
         OP_DNEGATE: begin
            r.pop_cells = 2; r.push_count = 1; r.push_is_double = 1; p1 = -td;
         end
         OP_MAX: begin r.pop_cells = 2; r.push_count = 1; p1 = (st > ss) ? t : s; end
         OP_MIN: begin r.pop_cells = 2; r.push_count = 1; p1 = (st < ss) ? t : s; end
         OP_NEGATE: begin r.pop_cells = 1; r.push_count = 1; p1 = CELL_W'(-t); end
         OP_UMUL: begin
            r.pop_cells = 2; r.push_count = 1; r.push_is_double = 1;
            p1 = DBL_W'(t) * DBL_W'(s);
         end
         OP_TRUE: begin r.push_count = 1; p1 = {CELL_W{1'b1}}; end
         OP_FALSE: begin r.push_count = 1; end
         OP_DUMOD: begin
            r.pop_cells = 4; r.push_count = 2; r.push_is_double = 1;
            if (td != 0) begin
               p1 = sd % td;
               p2 = sd / td;
            end
         end
         OP_UMOD: begin
            r.pop_cells = 2; r.push_count = 2;
            if (t != 0) begin
               p1 = s % t;
               p2 = s / t;
            end
         end
         OP_DIGIT: begin
            r.pop_cells = 2;
            if (s >= CHAR_ZERO && s <= CHAR_NINE) dval = s - CHAR_ZERO;
            else if (s >= CHAR_LA && s <= CHAR_LZ) dval = s - CHAR_LA + DIGIT_OFS;
            else dok = 1'b0;
            if (dok && dval >= t) dok = 1'b0;
            if (dok) begin
               r.push_count = 2; p1 = dval; p2 = {CELL_W{1'b1}};
            end else begin
               r.push_count = 1;
            end
         end
         default: ;
      endcase
      r.first_push = OUT_W'(p1);
      r.second_push = OUT_W'(p2);
      return r;
   endfunction

   assign pending_count = expected_results.size();

   // predict on each request beat, compare on each response beat
   always @(posedge clock) begin
      word_result_type got;
      word_result_type want;
      if (reset) begin
         fail_count <= 0;
         rsp_seen <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(eval_word(req_mon.opcode, req_mon.top_cell,
               req_mon.second_cell, req_mon.top_double, req_mon.second_double));
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsp_seen <= rsp_seen + 1;
            got = {rsp_mon.pop_cells, rsp_mon.push_count, rsp_mon.push_is_double,
                   rsp_mon.first_push, rsp_mon.second_push};
            if (expected_results.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result beat: %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got != want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected pop %0d cnt %0d dbl %0d %h %h, got pop %0d cnt %0d dbl %0d %h %h",
                        want.pop_cells, want.push_count, want.push_is_double,
                        want.first_push, want.second_push, got.pop_cells,
                        got.push_count, got.push_is_double, got.first_push,
                        got.second_push);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/sv/forth_stack_alu_tb.sv =====
module forth_stack_alu_tb;
   import fsa_pkg::*;

   localparam int LATENCY = 34;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   rsp_seen;
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   int   words_sent = 0;
   int   quiet_cycles = 0;

   fsa_req_if req_chan();
   fsa_rsp_if rsp_chan();

   forth_stack_alu uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   forth_stack_alu_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_mon(req_chan.sink),
      .rsp_mon(rsp_chan.sink),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .rsp_seen(rsp_seen)
   );

   always #5 clock = ~clock;

   // random receiver stalls
   initial rsp_chan.ready = 1'b0;
   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);

   // watchdog on cycles with no beat accepted
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else if (!reset) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // one word per beat; waits through random sender gaps
   task automatic send_word(logic [4:0] op, logic [CELL_W-1:0] t, logic [CELL_W-1:0] s,
                            logic [DBL_W-1:0] td, logic [DBL_W-1:0] sd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.top_cell <= t;
      req_chan.second_cell <= s;
      req_chan.top_double <= td;
      req_chan.second_double <= sd;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   function automatic logic [CELL_W-1:0] pick_cell();
      case ($urandom_range(5))
         0: return '0;
         1: return {CELL_W{1'b1}};
         2: return {1'b1, {(CELL_W-1){1'b0}}};
         3: return CELL_W'($urandom_range(40));
         default: return CELL_W'($urandom);
      endcase
   endfunction

   function automatic logic [DBL_W-1:0] pick_double();
      case ($urandom_range(4))
         0: return '0;
         1: return {DBL_W{1'b1}};
         2: return DBL_W'($urandom_range(300));
         default: return DBL_W'($urandom);
      endcase
   endfunction

   task automatic send_random(int n);
      logic [4:0] op;
      logic [CELL_W-1:0] s;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(19) == 0) ? 5'($urandom) : 5'($urandom_range(OP_DIGIT));
         s = pick_cell();
         // digit words mostly get characters near the accepted ranges
         if (op == OP_DIGIT && $urandom_range(3) != 0)
            s = CELL_W'($urandom_range(8'h2e, 8'h7c));
         send_word(op, pick_cell(), s, pick_double(), pick_double());
      end
      req_chan.valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      int tail;
      req_chan.valid = 1'b0;
      req_chan.opcode = '0;
      req_chan.top_cell = '0;
      req_chan.second_cell = '0;
      req_chan.top_double = '0;
      req_chan.second_double = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every word, extremes, zero divisors, digit edges
      for (int op = 0; op <= OP_DIGIT; op++)
         send_word(5'(op), 16'h8000, 16'hffff, 32'hffff_ffff, 32'h8000_0000);
      send_word(OP_SMOD, 16'hffff, 16'h8000, '0, '0);
      send_word(OP_SMOD, 16'h0000, 16'h1234, '0, '0);
      send_word(OP_UMOD, 16'h0000, 16'hffff, '0, '0);
      send_word(OP_DUMOD, '0, '0, 32'h0, 32'hdead_beef);
      send_word(OP_SMOD, 16'h0007, 16'hfff9, '0, '0);
      send_word(OP_HALF, 16'hffff, '0, '0, '0);
      send_word(OP_DIGIT, 16'd36, 16'h007a, '0, '0);
      send_word(OP_DIGIT, 16'd10, 16'h0039, '0, '0);
      send_word(OP_DIGIT, 16'd9, 16'h0039, '0, '0);
      send_word(OP_DIGIT, 16'd16, 16'h0041, '0, '0);
      send_word(5'd31, 16'hffff, 16'hffff, '1, '1);
      req_chan.valid <= 1'b0;
      // sender holds off until every result is back
      drain();

      // random phases of sender gaps and receiver stalls
      send_idle_pct = 0;  stall_pct = 0;  send_random(500);
      send_idle_pct = 87; stall_pct = 0;  send_random(300);
      drain();
      send_idle_pct = 0;  stall_pct = 87; send_random(300);
      send_idle_pct = 23; stall_pct = 23; send_random(500);
      send_idle_pct = 0;  stall_pct = 0;

      drain();
      tail = 0;
      while (tail < 4 * LATENCY) begin
         @(negedge clock);
         tail++;
      end

      $display("ran %0d forth words (all opcodes, undefined ones, zero divisors, digit bounds)",
               words_sent);
      $display("checked %0d result beats under sender gaps and receiver stalls", rsp_seen);
      if (fail_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== forth_stack_alu.f =====
hw/rtl/fsa_pkg.sv
hw/rtl/fsa_if.sv
hw/rtl/fsa_decode.sv
hw/rtl/fsa_div_stage.sv
hw/rtl/fsa_finish.sv
hw/rtl/forth_stack_alu.sv
tb/sv/forth_stack_alu_checker.sv
tb/sv/forth_stack_alu_tb.sv
